// ----- rtl/core/dtq_pkg.sv -----
package dtq_pkg;

  // field widths
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned REL_W   = 24;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned KIND_W  = 2;

  // stream payload widths, padded to whole bytes
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 24;

  // queue sizing
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned CNT_W           = $clog2(MAX_RESULTS);

  // request operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd3;

  // chain operations broadcast to every cell
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_FLUSH  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
    logic              cancel;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    entry_t     ins;
  } cell_ctl_t;

endpackage

// ----- rtl/core/dtq_cell.sv -----
module dtq_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dtq_pkg::cell_ctl_t            ctl_i,
  input  logic [dtq_pkg::TIME_W-1:0]    now_i,
  input  dtq_pkg::entry_t               left_i,
  input  dtq_pkg::entry_t               right_i,
  input  logic                          left_keep_i,
  output logic                          keep_o,
  output logic                          due_o,
  output dtq_pkg::entry_t               entry_o
);

  logic            valid_q, valid_d;
  dtq_pkg::entry_t pay_q, pay_d;

  // an entry stays put on insert when it is due no later than the new one
  assign keep_o = valid_q && (pay_q.deadline <= ctl_i.ins.deadline);
  assign due_o  = valid_q && (pay_q.deadline <= now_i);

  always_comb begin
    entry_o       = pay_q;
    entry_o.valid = valid_q;
  end

  // next entry from the broadcast operation
  always_comb begin
    valid_d = valid_q;
    pay_d   = pay_q;
    case (ctl_i.op)
      dtq_pkg::OP_INSERT: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            pay_d   = ctl_i.ins;
            valid_d = ctl_i.ins.valid;
          end else begin
            pay_d   = left_i;
            valid_d = left_i.valid;
          end
        end
      end
      dtq_pkg::OP_POP: begin
        pay_d   = right_i;
        valid_d = right_i.valid;
      end
      dtq_pkg::OP_FLUSH: begin
        valid_d = 1'b0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

endmodule

// ----- rtl/core/deadline_timer_queue_top.sv -----
// Deadline timer queue: holds up to QUEUE_DEPTH pending tasks sorted by absolute deadline in a
// chain of cells, with the head (earliest deadline) in cell 0, plus a 48-bit tick counter.
// Request kind on s_axis_tuser: add, tick or clear. An add answers with one accepted or rejected
// result (rejected without a callback or when the queue is full). A rejected add ends when it is
// accepted; an accepted add is accepted and forms the deadline (delay + now + 1), then enters an
// insert step in which every cell compares in parallel and the chain shifts right by one behind
// the insert point. A tick or clear is accepted, then reports one task per pop as the chain moves
// one place toward the head, and ends at its final result or when nothing is due
// or left. At most 16 results per request: a tick leaves further due tasks for later ticks, a
// clear empties all but reports only 16. Every result carries tlast on the final one of its
// request. Stalls on the result side add cycles.
module deadline_timer_queue_top #(
  parameter int unsigned QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // delay[23:0], task_tag[39:24], has_callback[40], has_cancel_check[41], zero pad
  input  logic [dtq_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  logic [dtq_pkg::FUNC_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_tag[15:0], out_cancel_check[16], zero pad
  output logic [dtq_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // kind[1:0]
  output logic [dtq_pkg::KIND_W-1:0]    m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_CLR  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [dtq_pkg::TIME_W-1:0]  now_q, now_d;
  logic [dtq_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  dtq_pkg::entry_t             ins_q, ins_d;
  logic                        out_valid_q, out_valid_d;
  logic [dtq_pkg::KIND_W-1:0]  out_kind_q, out_kind_d;
  logic [dtq_pkg::TAG_W-1:0]   out_tag_q, out_tag_d;
  logic                        out_flag_q, out_flag_d;
  logic                        out_last_q, out_last_d;

  dtq_pkg::cell_ctl_t          ctl;
  dtq_pkg::entry_t             entry_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      keep_w;
  logic [QUEUE_DEPTH-1:0]      due_w;
  logic                        next_due;
  logic                        next_valid;

  // request fields
  logic [dtq_pkg::REL_W-1:0]   in_rel;
  logic [dtq_pkg::TAG_W-1:0]   in_tag;
  logic                        in_cb;
  logic                        in_cc;
  logic                        s_hs;
  logic                        slot_free;
  logic                        full;
  logic                        head_ok;
  logic                        more;
  logic                        last_res;

  assign in_rel = s_axis_tdata[dtq_pkg::REL_W-1:0];
  assign in_tag = s_axis_tdata[dtq_pkg::REL_W +: dtq_pkg::TAG_W];
  assign in_cb  = s_axis_tdata[dtq_pkg::REL_W + dtq_pkg::TAG_W];
  assign in_cc  = s_axis_tdata[dtq_pkg::REL_W + dtq_pkg::TAG_W + 1];

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign full          = entry_w[QUEUE_DEPTH-1].valid;

  // chain of cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dtq_pkg::entry_t left_e;
    dtq_pkg::entry_t right_e;
    logic            left_keep;

    if (i == 0) begin : g_head
      assign left_e    = '0;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_e    = entry_w[i-1];
      assign left_keep = keep_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = entry_w[i+1];
    end

    dtq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .now_i       (now_q),
      .left_i      (left_e),
      .right_i     (right_e),
      .left_keep_i (left_keep),
      .keep_o      (keep_w[i]),
      .due_o       (due_w[i]),
      .entry_o     (entry_w[i])
    );
  end

  // look one cell ahead to mark the final result
  if (QUEUE_DEPTH > 1) begin : g_next
    assign next_due   = due_w[1];
    assign next_valid = entry_w[1].valid;
  end else begin : g_no_next
    assign next_due   = 1'b0;
    assign next_valid = 1'b0;
  end

  assign head_ok  = (state_q == ST_POP) ? due_w[0] : entry_w[0].valid;
  assign more     = (state_q == ST_POP) ? next_due : next_valid;
  assign last_res = !more || (cnt_q == dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS - 1));

  // sequencer and result register
  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    cnt_d       = cnt_q;
    ins_d       = ins_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_tag_d   = out_tag_q;
    out_flag_d  = out_flag_q;
    out_last_d  = out_last_q;
    ctl.op      = dtq_pkg::OP_HOLD;
    ctl.ins     = ins_q;

    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          case (s_axis_tuser)
            dtq_pkg::FUNC_ADD: begin
              out_valid_d = 1'b1;
              out_tag_d   = in_tag;
              out_flag_d  = in_cc;
              out_last_d  = 1'b1;
              if (in_cb && !full) begin
                out_kind_d     = dtq_pkg::KIND_ACCEPT;
                ins_d.valid    = 1'b1;
                ins_d.deadline = now_q + dtq_pkg::TIME_W'(in_rel) + dtq_pkg::TIME_W'(1);
                ins_d.tag      = in_tag;
                ins_d.cancel   = in_cc;
                state_d        = ST_INS;
              end else begin
                out_kind_d = dtq_pkg::KIND_REJECT;
              end
            end
            dtq_pkg::FUNC_TICK: begin
              now_d   = now_q + dtq_pkg::TIME_W'(1);
              cnt_d   = '0;
              state_d = ST_POP;
            end
            dtq_pkg::FUNC_CLEAR: begin
              cnt_d   = '0;
              state_d = ST_CLR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_INS: begin
        ctl.op  = dtq_pkg::OP_INSERT;
        state_d = ST_IDLE;
      end
      ST_POP, ST_CLR: begin
        if (!head_ok) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = (state_q == ST_POP) ? dtq_pkg::KIND_EXPIRE : dtq_pkg::KIND_DISCARD;
          out_tag_d   = entry_w[0].tag;
          out_flag_d  = entry_w[0].cancel;
          out_last_d  = last_res;
          cnt_d       = cnt_q + dtq_pkg::CNT_W'(1);
          ctl.op      = dtq_pkg::OP_POP;
          if (last_res) begin
            state_d = ST_IDLE;
            // a clear drops whatever is left unreported
            if (state_q == ST_CLR) begin
              ctl.op = dtq_pkg::OP_FLUSH;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    ins_q      <= ins_d;
    out_kind_q <= out_kind_d;
    out_tag_q  <= out_tag_d;
    out_flag_q <= out_flag_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(dtq_pkg::M_DATA_W - dtq_pkg::TAG_W - 1){1'b0}}, out_flag_q, out_tag_q};

endmodule

// ----- rtl/core/dtq_checker.sv -----
module dtq_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [dtq_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  logic [dtq_pkg::FUNC_W-1:0]    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [dtq_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input  logic [dtq_pkg::KIND_W-1:0]    m_axis_tuser,
  input  logic                          m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // add answers are single results
  a_add_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == dtq_pkg::KIND_ACCEPT ||
                      m_axis_tuser == dtq_pkg::KIND_REJECT) |-> m_axis_tlast)
    else $error("add result without tlast");

  // an add without callback is rejected on the next cycle with its own tag
  a_no_cb_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == dtq_pkg::FUNC_ADD &&
      !s_axis_tdata[dtq_pkg::REL_W + dtq_pkg::TAG_W] |=>
      m_axis_tvalid && m_axis_tuser == dtq_pkg::KIND_REJECT &&
      m_axis_tdata[dtq_pkg::TAG_W-1:0] ==
        $past(s_axis_tdata[dtq_pkg::REL_W +: dtq_pkg::TAG_W]))
    else $error("add without callback not rejected");

  // a tick or clear request takes the block out of idle, which drops s_axis_tready
  a_busy_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == dtq_pkg::FUNC_TICK ||
                                       s_axis_tuser == dtq_pkg::FUNC_CLEAR) |=>
      !s_axis_tready)
    else $error("request taken during scan");

endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- test/tb_deadline_timer_queue_top.sv -----
`timescale 1ns / 100ps

module tb_deadline_timer_queue_top;

  // unused operation code, must be ignored by the block
  localparam logic [dtq_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;

  localparam int unsigned DEPTH        = dtq_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } check_mode_e;

  typedef struct packed {
    logic [dtq_pkg::FUNC_W-1:0] fn;
    logic [dtq_pkg::REL_W-1:0]  rel;
    logic [dtq_pkg::TAG_W-1:0]  tag;
    logic                       cb;
    logic                       cc;
    check_mode_e                chk;
    logic [dtq_pkg::KIND_W-1:0] kind;
  } stim_row_t;

  typedef struct packed {
    logic [dtq_pkg::KIND_W-1:0] kind;
    logic [dtq_pkg::TAG_W-1:0]  tag;
    logic                       cc;
    logic                       last;
  } task_report_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [dtq_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
  logic [dtq_pkg::FUNC_W-1:0]   s_axis_tuser = dtq_pkg::FUNC_TICK;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [dtq_pkg::M_DATA_W-1:0] m_axis_tdata;
  logic [dtq_pkg::KIND_W-1:0]   m_axis_tuser;
  logic                         m_axis_tlast;

  // shadow copy of the timer queue
  logic [dtq_pkg::TIME_W-1:0] now_ticks_q;
  logic [dtq_pkg::TIME_W-1:0] shadow_due [DEPTH];
  logic [dtq_pkg::TAG_W-1:0]  shadow_tag [DEPTH];
  logic                       shadow_cc  [DEPTH];
  int unsigned                shadow_cnt;

  task_report_t pending_reports [$];
  stim_row_t    opening_rows [25];

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  deadline_timer_queue_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // remove the head entry of the shadow queue
  function automatic void shadow_drop_head();
    for (int i = 1; i < shadow_cnt; i++) begin
      shadow_due[i-1] = shadow_due[i];
      shadow_tag[i-1] = shadow_tag[i];
      shadow_cc[i-1]  = shadow_cc[i];
    end
    if (shadow_cnt > 0) shadow_cnt--;
  endfunction

  // work out the reports caused by one request and queue them
  function automatic void predict_reports(input logic [dtq_pkg::FUNC_W-1:0] fn,
                                          input logic [dtq_pkg::REL_W-1:0] rel,
                                          input logic [dtq_pkg::TAG_W-1:0] tag,
                                          input logic cb, input logic cc);
    logic [dtq_pkg::TIME_W-1:0] due;
    int unsigned pos;
    int unsigned n;
    n = 0;
    case (fn)
      dtq_pkg::FUNC_ADD: begin
        if (!cb || shadow_cnt >= DEPTH) begin
          pending_reports.push_back('{kind: dtq_pkg::KIND_REJECT, tag: tag, cc: cc,
                                      last: 1'b1});
        end else begin
          due = dtq_pkg::TIME_W'(rel) + now_ticks_q + 48'd1;
          pos = 0;
          // equal deadlines keep insertion order
          while (pos < shadow_cnt && shadow_due[pos] <= due) pos++;
          for (int i = shadow_cnt; i > pos; i--) begin
            shadow_due[i] = shadow_due[i-1];
            shadow_tag[i] = shadow_tag[i-1];
            shadow_cc[i]  = shadow_cc[i-1];
          end
          shadow_due[pos] = due;
          shadow_tag[pos] = tag;
          shadow_cc[pos]  = cc;
          shadow_cnt++;
          pending_reports.push_back('{kind: dtq_pkg::KIND_ACCEPT, tag: tag, cc: cc,
                                      last: 1'b1});
        end
      end
      dtq_pkg::FUNC_TICK: begin
        now_ticks_q = now_ticks_q + 48'd1;
        while (n < dtq_pkg::MAX_RESULTS && shadow_cnt > 0 && shadow_due[0] <= now_ticks_q) begin
          pending_reports.push_back('{kind: dtq_pkg::KIND_EXPIRE, tag: shadow_tag[0],
                                      cc: shadow_cc[0], last: 1'b0});
          n++;
          shadow_drop_head();
        end
      end
      dtq_pkg::FUNC_CLEAR: begin
        // whole queue goes, only the first MAX_RESULTS are reported
        while (shadow_cnt > 0) begin
          if (n < dtq_pkg::MAX_RESULTS) begin
            pending_reports.push_back('{kind: dtq_pkg::KIND_DISCARD, tag: shadow_tag[0],
                                        cc: shadow_cc[0], last: 1'b0});
            n++;
          end
          shadow_drop_head();
        end
      end
      default: ;
    endcase
    if (n > 0) pending_reports[pending_reports.size()-1].last = 1'b1;
  endfunction

  // drive one request and record what it should produce
  task automatic send_request(input logic [dtq_pkg::FUNC_W-1:0] fn,
                              input logic [dtq_pkg::REL_W-1:0] rel,
                              input logic [dtq_pkg::TAG_W-1:0] tag, input logic cb,
                              input logic cc, input check_mode_e chk,
                              input logic [dtq_pkg::KIND_W-1:0] kind);
    int unsigned mark;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {6'd0, cc, cb, tag, rel};
    do @(posedge clk_i); while (!s_axis_tready);
    mark = pending_reports.size();
    predict_reports(fn, rel, tag, cb, cc);
    // rows with a hand-written answer replace the predicted results with their own, or with none
    if (chk != CHK_MODEL) begin
      while (pending_reports.size() > mark) void'(pending_reports.pop_back());
      if (chk == CHK_ONE)
        pending_reports.push_back('{kind: kind, tag: tag, cc: cc, last: 1'b1});
    end
    @(negedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input task_report_t want,
                               input task_report_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t %s: expected kind %0d tag %h cc %b last %b, got kind %0d tag %h cc %b last %b",
               $realtime, what, want.kind, want.tag, want.cc, want.last,
               got.kind, got.tag, got.cc, got.last);
  endtask

  // result checker
  always @(posedge clk_i) begin
    task_report_t got;
    task_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: m_axis_tuser, tag: m_axis_tdata[15:0], cc: m_axis_tdata[16],
              last: m_axis_tlast};
      if (pending_reports.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.kind !== want.kind || got.tag !== want.tag ||
            got.cc !== want.cc || got.last !== want.last)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // stimulus
  initial begin
    logic [dtq_pkg::FUNC_W-1:0] fn;
    logic [dtq_pkg::REL_W-1:0]  rel;
    logic                       cb;
    int unsigned                pick;
    int unsigned                src_pcts [4];
    int unsigned                snk_pcts [4];

    src_pcts = '{0, 54, 0, 10};
    snk_pcts = '{0, 0, 54, 10};

    opening_rows = '{
      // empty queue after reset: nothing due, nothing to discard, unused code ignored
      '{dtq_pkg::FUNC_TICK,  24'h000000, 16'h0000, 1'b0, 1'b0, CHK_NONE,  dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_CLEAR, 24'h000000, 16'h0000, 1'b0, 1'b0, CHK_NONE,  dtq_pkg::KIND_ACCEPT},
      '{FUNC_NOP,            24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1, CHK_NONE,  dtq_pkg::KIND_ACCEPT},
      // add without callback, then a far and a near add and a tick
      '{dtq_pkg::FUNC_ADD,   24'hFFFFFF, 16'hFFFF, 1'b0, 1'b1, CHK_ONE,   dtq_pkg::KIND_REJECT},
      '{dtq_pkg::FUNC_ADD,   24'hFFFFFF, 16'h8001, 1'b1, 1'b1, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h7FFE, 1'b1, 1'b0, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_TICK,  24'h000000, 16'h0000, 1'b0, 1'b0, CHK_MODEL, dtq_pkg::KIND_ACCEPT},
      // fill up with ties and near deadlines
      '{dtq_pkg::FUNC_ADD,   24'h000001, 16'h1000, 1'b1, 1'b1, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h1001, 1'b1, 1'b0, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h1002, 1'b1, 1'b1, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000002, 16'h1003, 1'b1, 1'b0, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h1004, 1'b1, 1'b1, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000001, 16'h1005, 1'b1, 1'b0, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h1006, 1'b1, 1'b1, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h1007, 1'b1, 1'b0, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h1008, 1'b1, 1'b1, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h1009, 1'b1, 1'b0, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h100A, 1'b1, 1'b1, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h100B, 1'b1, 1'b0, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h100C, 1'b1, 1'b1, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h100D, 1'b1, 1'b0, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_ADD,   24'h000000, 16'h100E, 1'b1, 1'b1, CHK_ONE,   dtq_pkg::KIND_ACCEPT},
      // queue full
      '{dtq_pkg::FUNC_ADD,   24'h000003, 16'h0BAD, 1'b1, 1'b1, CHK_ONE,   dtq_pkg::KIND_REJECT},
      '{dtq_pkg::FUNC_TICK,  24'h000000, 16'h0000, 1'b0, 1'b0, CHK_MODEL, dtq_pkg::KIND_ACCEPT},
      '{dtq_pkg::FUNC_CLEAR, 24'h000000, 16'h0000, 1'b0, 1'b0, CHK_MODEL, dtq_pkg::KIND_ACCEPT}
    };

    now_ticks_q = '0;
    shadow_cnt  = 0;

    // reset
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (opening_rows[i])
      send_request(opening_rows[i].fn, opening_rows[i].rel, opening_rows[i].tag,
                   opening_rows[i].cb, opening_rows[i].cc, opening_rows[i].chk,
                   opening_rows[i].kind);

    // random traffic under each idle and stall mix
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = src_pcts[ph];
      snk_stall_pct = snk_pcts[ph];
      for (int k = 0; k < 50; k++) begin
        pick = $urandom_range(0, 99);
        cb = 1'b1;
        if (pick < 50) fn = dtq_pkg::FUNC_ADD;
        else if (pick < 55) begin
          fn = dtq_pkg::FUNC_ADD;
          cb = 1'b0;
        end
        else if (pick < 90) fn = dtq_pkg::FUNC_TICK;
        else if (pick < 96) fn = dtq_pkg::FUNC_CLEAR;
        else fn = FUNC_NOP;
        // mostly short delays so tasks expire, some long ones to fill the queue
        if ($urandom_range(0, 9) < 7) rel = dtq_pkg::REL_W'($urandom_range(0, 15));
        else if ($urandom_range(0, 1) == 1) rel = dtq_pkg::REL_W'($urandom_range(16, 300));
        else rel = dtq_pkg::REL_W'($urandom);
        send_request(fn, rel, dtq_pkg::TAG_W'($urandom), cb, 1'($urandom_range(0, 1)),
                     CHK_MODEL, dtq_pkg::KIND_ACCEPT);
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
